@@ rtl/core/pngenc_pkg.sv @@
// ----------------------------------------------------------------------------
// pngenc_pkg
// Shared widths, register indexes, handshake structs and CRC-32 helpers for
// the stored-deflate PNG encoder.
// ----------------------------------------------------------------------------
package pngenc_pkg;

    localparam int DIM_W     = 14;     // image_width / image_height
    localparam int ROW_W     = 15;     // bytes per scanline, 3 * width
    localparam int RAW_W     = 28;     // raw zlib payload byte count
    localparam int BLK_W     = 16;     // stored block length
    localparam int CNT_W     = 6;      // per-item result count
    localparam int IDX_W     = 6;      // byte index inside a header run
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    localparam logic [CNT_W-1:0] RESULT_LIMIT = 6'd50;
    localparam logic [16:0]      ADLER_MOD    = 17'd65521;
    localparam logic [31:0]      CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0]      CRC_ONES     = 32'hFFFFFFFF;

    localparam logic [IDX_W-1:0] HEAD_LAST = 6'd42;
    localparam logic [IDX_W-1:0] HEAD_ZLEN = 6'd33;
    localparam logic [IDX_W-1:0] TAIL_LAST = 6'd19;
    localparam logic [IDX_W-1:0] BHDR_LAST = 6'd4;

    // Effective (clamped) image dimensions.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } pngenc_dims_t;

    // Head of the pixel queue as seen by the back end.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } pngenc_deq_t;

    // Back end status toward the front end.
    typedef struct packed {
        logic pop;
        logic idle;
    } pngenc_bstat_t;

    // One entry of the reflected CRC-32 table.
    function automatic logic [31:0] crc_lut_entry(input logic [7:0] idx);
        logic [31:0] c;
        c = {24'd0, idx};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] crc_shift_byte(input logic [31:0] c, input logic [7:0] b);
        return crc_lut_entry(c[7:0] ^ b) ^ (c >> 8);
    endfunction

endpackage

@@ rtl/core/png_rgb_stored_deflate_encoder.sv @@
// ----------------------------------------------------------------------------
// png_rgb_stored_deflate_encoder
// Turns RGB bytes in raster order into a complete 8-bit truecolor PNG file
// whose IDAT holds stored (uncompressed) deflate blocks.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+------------------------------
//  pixel in | input     | in_valid / in_stall    | pixel_byte
//  file out | output    | out_valid / out_stall  | out_byte, run_last, file_end
//  config   | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A pixel beat moves one byte per cycle, unless stalled, through a four-entry
// queue into the byte sequencer, which emits one output byte per cycle while
// the output is not stalled. The first pixel of a file costs a setup step
// plus 43 header bytes; each stored block costs 5 header bytes, each scanline
// one filter byte, and the last pixel a 20-byte trailer. The IDAT length
// comes from a multiply and a reciprocal multiply that the setup step starts
// and that finish while the signature and IHDR are sent. Reset clears all
// control state and loads width and height of one. An output stall holds the
// result register; the queue keeps accepting pixel beats until it is full.
//
// ----------------------------------------------------------------------------
module png_rgb_stored_deflate_encoder
    import pngenc_pkg::*;
#(
    parameter int MAX_DIMENSION    = 8192,
    parameter int STORED_BLOCK_MAX = 65535
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           pixel_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 run_last,
    output logic                 file_end,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    pngenc_deq_t      deq;
    pngenc_dims_t     dims;
    pngenc_dims_t     calc_dims;
    pngenc_bstat_t    bstat;
    logic             calc_start;
    logic [RAW_W-1:0] raw_total;
    logic [31:0]      zlen;
    logic             zlen_done;

    // Front end: configuration and pixel queue.
    pngenc_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_byte (pixel_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .bstat      (bstat),
        .deq        (deq),
        .dims       (dims)
    );

    // Length unit, started once per file by the sequencer.
    pngenc_hdrcalc #(
        .STORED_BLOCK_MAX (STORED_BLOCK_MAX)
    ) u_hdrcalc (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (calc_start),
        .dims      (calc_dims),
        .raw_total (raw_total),
        .zlen      (zlen),
        .done      (zlen_done)
    );

    // Back end: byte sequencer, checksums and output register.
    pngenc_back #(
        .STORED_BLOCK_MAX (STORED_BLOCK_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .deq        (deq),
        .dims       (dims),
        .bstat      (bstat),
        .calc_start (calc_start),
        .calc_dims  (calc_dims),
        .raw_total  (raw_total),
        .zlen       (zlen),
        .zlen_done  (zlen_done),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .file_end   (file_end)
    );

endmodule

@@ rtl/core/pngenc_front.sv @@
// ----------------------------------------------------------------------------
// pngenc_front
// Configuration registers and the pixel queue that decouples the input
// channel from the byte sequencer.
// ----------------------------------------------------------------------------
module pngenc_front
    import pngenc_pkg::*;
#(
    parameter int MAX_DIMENSION = 8192
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           pixel_byte,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  pngenc_bstat_t        bstat,
    output pngenc_deq_t          deq,
    output pngenc_dims_t         dims
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;
    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_DIMENSION);

    logic [7:0]       fifo_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic             push;

    assign cfg_ready = 1'b1;
    assign in_stall  = (count_reg == (PTR_W+1)'(DEPTH));
    assign push      = in_valid && !in_stall;

    assign deq.valid = (count_reg != '0);
    assign deq.data  = fifo_mem[rd_ptr_reg];

    // Zero reads as one, oversize saturates.
    assign dims.width  = (width_reg == '0) ? DIM_W'(1) :
                         ((width_reg > MAX_DIM) ? MAX_DIM : width_reg);
    assign dims.height = (height_reg == '0) ? DIM_W'(1) :
                         ((height_reg > MAX_DIM) ? MAX_DIM : height_reg);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = bstat.pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(bstat.pop);
        width_next  = width_reg;
        height_next = height_reg;
        // Writes are dropped while an image is in progress.
        if (cfg_valid && cfg_ready && bstat.idle)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_next  = cfg_data;
                CFG_HEIGHT: height_next = cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= pixel_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

endmodule

@@ rtl/core/pngenc_hdrcalc.sv @@
// ----------------------------------------------------------------------------
// pngenc_hdrcalc
// Works out the raw byte count and the IDAT length of a new file: one
// multiply, then a reciprocal multiplication for the stored block count.
// ----------------------------------------------------------------------------
module pngenc_hdrcalc
    import pngenc_pkg::*;
#(
    parameter int STORED_BLOCK_MAX = 65535
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  pngenc_dims_t     dims,
    output logic [RAW_W-1:0] raw_total,
    output logic [31:0]      zlen,
    output logic             done
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MUL  = 3'd1;
    localparam logic [2:0] PH_LOAD = 3'd2;
    localparam logic [2:0] PH_RCP  = 3'd3;
    localparam logic [2:0] PH_SUM  = 3'd4;

    // Rounded-up reciprocal of the block size. With the shift below the
    // product gives the exact quotient for every dividend of RAW_W bits.
    localparam int          RCP_SHIFT = RAW_W + $clog2(STORED_BLOCK_MAX);
    localparam logic [63:0] RCP_WIDE  = ((64'd1 << RCP_SHIFT) +
                                         64'(STORED_BLOCK_MAX - 1)) /
                                        64'(STORED_BLOCK_MAX);
    localparam logic [30:0] RCP_MUL   = RCP_WIDE[30:0];
    localparam int          PROD_W    = RAW_W + 31;

    localparam logic [RAW_W-1:0] ROUND = RAW_W'(STORED_BLOCK_MAX - 1);

    logic [2:0]        ph_reg, ph_next;
    logic [RAW_W-1:0]  raw_reg, raw_next;
    logic [RAW_W-1:0]  dvd_reg, dvd_next;
    logic [31:0]       zlen_reg, zlen_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] prod;
    logic [ROW_W-1:0]  row_plus;

    assign row_plus = ROW_W'({dims.width, 1'b0}) + ROW_W'(dims.width) + ROW_W'(1);
    assign prod     = PROD_W'(dvd_reg) * PROD_W'(RCP_MUL);

    always_comb
    begin
        ph_next   = ph_reg;
        raw_next  = raw_reg;
        dvd_next  = dvd_reg;
        zlen_next = zlen_reg;
        done_next = done_reg;
        if (start)
        begin
            ph_next   = PH_MUL;
            done_next = 1'b0;
        end
        else
        begin
            unique case (ph_reg)
                PH_IDLE: ;
                PH_MUL:
                begin
                    raw_next = RAW_W'(row_plus * dims.height);
                    ph_next  = PH_LOAD;
                end
                PH_LOAD:
                begin
                    dvd_next = raw_reg + ROUND;
                    ph_next  = PH_RCP;
                end
                PH_RCP:
                begin
                    // Number of stored blocks, rounded up.
                    dvd_next = RAW_W'(prod >> RCP_SHIFT);
                    ph_next  = PH_SUM;
                end
                PH_SUM:
                begin
                    // zlib header 2, Adler 4, five header bytes per block.
                    zlen_next = 32'(raw_reg) + {2'b00, dvd_reg, 2'b00} + 32'(dvd_reg) + 32'd6;
                    done_next = 1'b1;
                    ph_next   = PH_IDLE;
                end
                default: ph_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg  <= raw_next;
        dvd_reg  <= dvd_next;
        zlen_reg <= zlen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    assign raw_total = raw_reg;
    assign zlen      = zlen_reg;
    assign done      = done_reg;

endmodule

@@ rtl/core/pngenc_back.sv @@
// ----------------------------------------------------------------------------
// pngenc_back
// Byte sequencer: file header, stored block headers, filter and pixel bytes,
// trailer. Keeps CRC-32 and Adler-32 and drives the output register.
// ----------------------------------------------------------------------------
module pngenc_back
    import pngenc_pkg::*;
#(
    parameter int STORED_BLOCK_MAX = 65535
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  pngenc_deq_t      deq,
    input  pngenc_dims_t     dims,
    output pngenc_bstat_t    bstat,
    output logic             calc_start,
    output pngenc_dims_t     calc_dims,
    input  logic [RAW_W-1:0] raw_total,
    input  logic [31:0]      zlen,
    input  logic             zlen_done,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             file_end
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HEAD = 3'd1;
    localparam logic [2:0] ST_RUN  = 3'd2;
    localparam logic [2:0] ST_TAIL = 3'd3;

    localparam logic [RAW_W-1:0] BLK_MAX = RAW_W'(STORED_BLOCK_MAX);

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             act_reg, act_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      crc_reg, crc_next;
    logic [15:0]      lo_reg, lo_next;
    logic [15:0]      hi_reg, hi_next;
    logic [RAW_W-1:0] left_reg, left_next;
    logic [BLK_W-1:0] room_reg, room_next;
    logic [ROW_W-1:0] rcnt_reg, rcnt_next;
    logic [ROW_W-1:0] rlen_reg, rlen_next;
    logic             fdone_reg, fdone_next;
    pngenc_dims_t     dims_reg, dims_next;
    logic             ov_reg, ov_next;
    logic [7:0]       ob_reg, ob_next;
    logic             rl_reg, rl_next;
    logic             fe_reg, fe_next;

    logic             slot, emit, in_crc, crc_restart, is_raw, pop, step_end, file_done;
    logic [7:0]       bval;
    logic [CNT_W-1:0] cnt_base;
    logic             need_hdr, filt_pend, fin, shown;
    logic [RAW_W-1:0] rem, cons;
    logic [BLK_W-1:0] bn;
    logic [16:0]      lo_sum, hi_sum;
    logic [15:0]      lo_mod, hi_mod;
    logic [31:0]      crc_out, adler;
    logic [ROW_W-1:0] rcnt_inc;

    assign slot      = !ov_reg || !out_stall;
    assign cnt_base  = act_reg ? cnt_reg : '0;
    assign need_hdr  = (room_reg == '0) && (left_reg != '0);
    assign filt_pend = (rcnt_reg == '0) && !fdone_reg;
    assign bn        = (left_reg > BLK_MAX) ? BLK_W'(BLK_MAX) : left_reg[BLK_W-1:0];
    assign crc_out   = crc_reg ^ CRC_ONES;
    assign adler     = {hi_reg, lo_reg};
    assign rcnt_inc  = rcnt_reg + 1'b1;

    // Does the item now in work end the file? Needed when the result limit
    // cuts the item short.
    assign rem  = (state_reg == ST_HEAD) ? raw_total : left_reg;
    assign cons = ((state_reg == ST_HEAD) || filt_pend) ? RAW_W'(2) : RAW_W'(1);
    assign fin  = (state_reg == ST_TAIL) || (rem == cons);

    function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] sel);
        return v[8*(3-sel) +: 8];
    endfunction

    function automatic logic [7:0] head_byte(input logic [IDX_W-1:0] i,
                                             input pngenc_dims_t d,
                                             input logic [31:0] crc_v,
                                             input logic [31:0] zl);
        logic [7:0] b;
        b = 8'h00;
        unique case (i)
            6'd0:  b = 8'd137;
            6'd1:  b = 8'h50;
            6'd2:  b = 8'h4E;
            6'd3:  b = 8'h47;
            6'd4:  b = 8'h0D;
            6'd5:  b = 8'h0A;
            6'd6:  b = 8'h1A;
            6'd7:  b = 8'h0A;
            6'd11: b = 8'd13;
            6'd12: b = 8'h49;
            6'd13: b = 8'h48;
            6'd14: b = 8'h44;
            6'd15: b = 8'h52;
            6'd18: b = {2'b00, d.width[DIM_W-1:8]};
            6'd19: b = d.width[7:0];
            6'd22: b = {2'b00, d.height[DIM_W-1:8]};
            6'd23: b = d.height[7:0];
            6'd24: b = 8'd8;
            6'd25: b = 8'd2;
            6'd29, 6'd30, 6'd31, 6'd32: b = be_byte(crc_v, 2'(i - 6'd29));
            6'd33, 6'd34, 6'd35, 6'd36: b = be_byte(zl, 2'(i - 6'd33));
            6'd37: b = 8'h49;
            6'd38: b = 8'h44;
            6'd39: b = 8'h41;
            6'd40: b = 8'h54;
            6'd41: b = 8'h78;
            6'd42: b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] tail_byte(input logic [IDX_W-1:0] i,
                                             input logic [31:0] adl,
                                             input logic [31:0] crc_v);
        logic [7:0] b;
        b = 8'h00;
        unique case (i)
            6'd0, 6'd1, 6'd2, 6'd3:     b = be_byte(adl, 2'(i));
            6'd4, 6'd5, 6'd6, 6'd7:     b = be_byte(crc_v, 2'(i - 6'd4));
            6'd12: b = 8'h49;
            6'd13: b = 8'h45;
            6'd14: b = 8'h4E;
            6'd15: b = 8'h44;
            6'd16, 6'd17, 6'd18, 6'd19: b = be_byte(crc_v, 2'(i - 6'd16));
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        act_next    = act_reg;
        left_next   = left_reg;
        room_next   = room_reg;
        rcnt_next   = rcnt_reg;
        rlen_next   = rlen_reg;
        fdone_next  = fdone_reg;
        dims_next   = dims_reg;
        emit        = 1'b0;
        bval        = 8'h00;
        in_crc      = 1'b0;
        crc_restart = 1'b0;
        is_raw      = 1'b0;
        pop         = 1'b0;
        step_end    = 1'b0;
        file_done   = 1'b0;
        calc_start  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (deq.valid)
                begin
                    state_next = ST_HEAD;
                    idx_next   = '0;
                    act_next   = 1'b1;
                    dims_next  = dims;
                    rlen_next  = ROW_W'({dims.width, 1'b0}) + ROW_W'(dims.width);
                    rcnt_next  = '0;
                    fdone_next = 1'b0;
                    calc_start = 1'b1;
                end
            end
            ST_HEAD:
            begin
                if (slot && !((idx_reg >= HEAD_ZLEN) && !zlen_done))
                begin
                    emit        = 1'b1;
                    bval        = head_byte(idx_reg, dims_reg, crc_out, zlen);
                    in_crc      = ((idx_reg >= 6'd12) && (idx_reg <= 6'd28)) ||
                                  (idx_reg >= 6'd37);
                    crc_restart = (idx_reg == 6'd12) || (idx_reg == 6'd37);
                    if (idx_reg == HEAD_LAST)
                    begin
                        state_next = ST_RUN;
                        idx_next   = '0;
                        left_next  = raw_total;
                        room_next  = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                if (slot && (act_reg || deq.valid))
                begin
                    emit   = 1'b1;
                    in_crc = 1'b1;
                    if (need_hdr)
                    begin
                        unique case (idx_reg)
                            6'd0:    bval = {7'd0, (BLK_W'(left_reg) == bn) &&
                                                    (left_reg <= BLK_MAX)};
                            6'd1:    bval = bn[7:0];
                            6'd2:    bval = bn[15:8];
                            6'd3:    bval = ~bn[7:0];
                            default: bval = ~bn[15:8];
                        endcase
                        if (idx_reg == BHDR_LAST)
                        begin
                            idx_next  = '0;
                            room_next = bn;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                        act_next = 1'b1;
                    end
                    else if (filt_pend)
                    begin
                        bval       = 8'h00;
                        is_raw     = 1'b1;
                        fdone_next = 1'b1;
                        act_next   = 1'b1;
                    end
                    else
                    begin
                        bval       = deq.data;
                        is_raw     = 1'b1;
                        pop        = 1'b1;
                        fdone_next = 1'b0;
                        rcnt_next  = (rcnt_inc >= rlen_reg) ? '0 : rcnt_inc;
                        if (left_reg == RAW_W'(1))
                        begin
                            state_next = ST_TAIL;
                            idx_next   = '0;
                            act_next   = 1'b1;
                        end
                        else
                        begin
                            step_end = 1'b1;
                            act_next = 1'b0;
                        end
                    end
                end
            end
            ST_TAIL:
            begin
                if (slot)
                begin
                    emit        = 1'b1;
                    bval        = tail_byte(idx_reg, adler, crc_out);
                    in_crc      = (idx_reg <= 6'd3) ||
                                  ((idx_reg >= 6'd12) && (idx_reg <= 6'd15));
                    crc_restart = (idx_reg == 6'd12);
                    if (idx_reg == TAIL_LAST)
                    begin
                        state_next = ST_IDLE;
                        idx_next   = '0;
                        step_end   = 1'b1;
                        file_done  = 1'b1;
                        act_next   = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Every raw byte uses up one byte of the payload and of the block.
        if (is_raw)
        begin
            if (left_reg != '0)
            begin
                left_next = left_reg - 1'b1;
            end
            if (room_reg != '0)
            begin
                room_next = room_reg - 1'b1;
            end
        end
    end

    // Adler-32 and CRC-32 update.
    always_comb
    begin
        lo_sum  = {1'b0, lo_reg} + {9'd0, bval};
        lo_mod  = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
        hi_sum  = {1'b0, hi_reg} + {1'b0, lo_mod};
        hi_mod  = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
        lo_next = lo_reg;
        hi_next = hi_reg;
        crc_next = crc_reg;
        if (calc_start)
        begin
            lo_next = 16'd1;
            hi_next = 16'd0;
        end
        else if (is_raw)
        begin
            lo_next = lo_mod;
            hi_next = hi_mod;
        end
        if (emit && in_crc)
        begin
            crc_next = crc_shift_byte(crc_restart ? CRC_ONES : crc_reg, bval);
        end
    end

    // Result count per item and the output register.
    always_comb
    begin
        shown    = emit && (cnt_base < RESULT_LIMIT);
        cnt_next = cnt_reg;
        if (calc_start)
        begin
            cnt_next = '0;
        end
        else if (emit)
        begin
            cnt_next = shown ? cnt_base + 1'b1 : cnt_base;
        end
        ov_next = ov_reg;
        ob_next = ob_reg;
        rl_next = rl_reg;
        fe_next = fe_reg;
        if (slot)
        begin
            ov_next = shown;
        end
        if (shown)
        begin
            ob_next = bval;
            rl_next = step_end || (cnt_base == RESULT_LIMIT - 1'b1);
            fe_next = file_done || ((cnt_base == RESULT_LIMIT - 1'b1) && fin);
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg   <= ob_next;
        rl_reg   <= rl_next;
        fe_reg   <= fe_next;
        dims_reg <= dims_next;
        rlen_reg <= rlen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            act_reg   <= 1'b0;
            cnt_reg   <= '0;
            crc_reg   <= CRC_ONES;
            lo_reg    <= 16'd1;
            hi_reg    <= 16'd0;
            left_reg  <= '0;
            room_reg  <= '0;
            rcnt_reg  <= '0;
            fdone_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            act_reg   <= act_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            left_reg  <= left_next;
            room_reg  <= room_next;
            rcnt_reg  <= rcnt_next;
            fdone_reg <= fdone_next;
            ov_reg    <= ov_next;
        end
    end

    assign bstat.pop  = pop;
    assign bstat.idle = (state_reg == ST_IDLE);
    assign calc_dims  = (state_reg == ST_IDLE) ? dims : dims_reg;
    assign out_valid  = ov_reg;
    assign out_byte   = ob_reg;
    assign run_last   = rl_reg;
    assign file_end   = fe_reg;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> deq.valid)
        else $error("pixel pop from an empty queue");

    a_tail_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAIL) |-> (left_reg == '0))
        else $error("trailer started with raw bytes outstanding");

    a_zlen_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (state_reg == ST_HEAD) && (idx_reg >= HEAD_ZLEN)) |-> zlen_done)
        else $error("IDAT length sent before it was computed");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && fe_reg) |-> rl_reg)
        else $error("file end beat without item end");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stored-deflate PNG encoder. Pixel beats are
// sent from a directed table and then as random images. A predictor in the
// bench builds every expected file byte, and each output beat is checked
// against it.
// ----------------------------------------------------------------------------
module tb
    import pngenc_pkg::*;
();

    // One expected beat of the file stream.
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       fin;
    } file_beat_t;

    // Directed table rows are either a register write or a pixel beat.
    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [DIM_W-1:0]     value;
        bit                   known;      // first output byte is typed in
        logic [7:0]           first_byte;
    } stim_row_t;

    localparam int MAX_DIM   = 8192;
    localparam int BLOCK_MAX = 65535;
    localparam int ROW_COUNT = 21;
    localparam logic [7:0] SIG_FIRST = 8'd137;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           pixel_byte = 8'd0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           out_byte;
    logic                 run_last;
    logic                 file_end;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
    logic [DIM_W-1:0]     cfg_data = '0;

    // Shadow copy of the encoder state, kept by the predictor.
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [31:0]      crc_acc;
    int unsigned      adler_lo;
    int unsigned      adler_hi;
    int unsigned      raw_remaining;
    int unsigned      room_left;
    int unsigned      row_pos;
    bit               in_image;

    file_beat_t file_bytes_due[$];
    file_beat_t step_bytes[$];
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    stim_row_t  stim_table[ROW_COUNT];

    always #5 clk = ~clk;

    png_rgb_stored_deflate_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_byte (pixel_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .file_end   (file_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // A generous ceiling, far above a full run with every stall.
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return v;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Appends one byte of the current step; chunk bytes also feed the CRC.
    task automatic emit(input logic [7:0] b, input bit in_crc);
        file_beat_t beat;
        if (in_crc)
        begin
            crc_acc = crc_byte(crc_acc, b);
        end
        beat.data = b;
        beat.last = 1'b0;
        beat.fin  = 1'b0;
        step_bytes.push_back(beat);
    endtask

    task automatic emit_word(input logic [31:0] v, input bit in_crc);
        emit(v[31:24], in_crc);
        emit(v[23:16], in_crc);
        emit(v[15:8], in_crc);
        emit(v[7:0], in_crc);
    endtask

    // A raw zlib byte: opens a stored block when the previous one is full.
    task automatic emit_raw(input logic [7:0] b);
        int unsigned len;
        if (room_left == 0 && raw_remaining != 0)
        begin
            len = (raw_remaining > BLOCK_MAX) ? BLOCK_MAX : raw_remaining;
            emit((len == raw_remaining) ? 8'd1 : 8'd0, 1'b1);
            emit(len[7:0], 1'b1);
            emit(len[15:8], 1'b1);
            emit(~len[7:0], 1'b1);
            emit(~len[15:8], 1'b1);
            room_left = len;
        end
        emit(b, 1'b1);
        adler_lo = (adler_lo + b) % 65521;
        adler_hi = (adler_hi + adler_lo) % 65521;
        if (room_left != 0)
        begin
            room_left--;
        end
        if (raw_remaining != 0)
        begin
            raw_remaining--;
        end
    endtask

    // Signature, IHDR and the opening of IDAT for a new file.
    task automatic open_file();
        int unsigned w;
        int unsigned h;
        int unsigned raw;
        int unsigned blocks;
        logic [7:0]  sig[8];
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        raw = (3 * w + 1) * h;
        blocks = (raw + BLOCK_MAX - 1) / BLOCK_MAX;
        sig = '{SIG_FIRST, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
        foreach (sig[i])
        begin
            emit(sig[i], 1'b0);
        end
        emit_word(32'd13, 1'b0);
        crc_acc = '1;
        emit_word("IHDR", 1'b1);
        emit_word(w, 1'b1);
        emit_word(h, 1'b1);
        emit(8'd8, 1'b1);
        emit(8'd2, 1'b1);
        emit(8'd0, 1'b1);
        emit(8'd0, 1'b1);
        emit(8'd0, 1'b1);
        emit_word(~crc_acc, 1'b0);
        emit_word(2 + raw + blocks * 5 + 4, 1'b0);
        crc_acc = '1;
        emit_word("IDAT", 1'b1);
        emit(8'h78, 1'b1);
        emit(8'h01, 1'b1);
        adler_lo = 1;
        adler_hi = 0;
        raw_remaining = raw;
        room_left = 0;
        row_pos = 0;
        in_image = 1'b1;
    endtask

    // Expected file bytes caused by one accepted pixel beat.
    task automatic encode_pixel(input logic [7:0] b);
        step_bytes.delete();
        if (!in_image)
        begin
            open_file();
        end
        if (row_pos == 0)
        begin
            emit_raw(8'd0);
        end
        emit_raw(b);
        row_pos++;
        if (row_pos >= 3 * clamp_dim(width_reg))
        begin
            row_pos = 0;
        end
        if (raw_remaining == 0)
        begin
            emit_word({adler_hi[15:0], adler_lo[15:0]}, 1'b1);
            emit_word(~crc_acc, 1'b0);
            emit_word(32'd0, 1'b0);
            crc_acc = '1;
            emit_word("IEND", 1'b1);
            emit_word(~crc_acc, 1'b0);
            in_image = 1'b0;
            step_bytes[$].fin = 1'b1;
        end
        step_bytes[$].last = 1'b1;
        foreach (step_bytes[i])
        begin
            file_bytes_due.push_back(step_bytes[i]);
        end
    endtask

    // Drives one pixel beat; returns at the edge that accepts it.
    task automatic send_pixel(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        pixel_byte = b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        encode_pixel(b);
    endtask

    // Holds the sender until the output side has delivered everything.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (file_bytes_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    // Register writes happen only with nothing in flight. Writes during an
    // image are accepted by the port but must not change the dimensions.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (!in_image)
        begin
            if (idx == CFG_WIDTH)
            begin
                width_reg = v;
            end
            else if (idx == CFG_HEIGHT)
            begin
                height_reg = v;
            end
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        send_pixel(8'($urandom_range(0, 255)));
        // Now and then poke a register mid-image; it has to be ignored.
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg($urandom_range(0, 1) ? CFG_WIDTH : CFG_HEIGHT, DIM_W'($urandom));
        end
        while (in_image)
        begin
            send_pixel(8'($urandom_range(0, 255)));
        end
    endtask

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Output checker: every accepted beat is matched to the oldest expectation.
    always @(posedge clk)
    begin
        file_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (file_bytes_due.size() == 0)
            begin
                note_mismatch("unexpected beat", 0, out_byte);
            end
            else
            begin
                want = file_bytes_due.pop_front();
                if (out_byte !== want.data)
                begin
                    note_mismatch("out_byte", want.data, out_byte);
                end
                if (run_last !== want.last)
                begin
                    note_mismatch("run_last", want.last, run_last);
                end
                if (file_end !== want.fin)
                begin
                    note_mismatch("file_end", want.fin, file_end);
                end
            end
        end
    end

    initial
    begin
        int sent;
        int pct_send[4];
        int pct_stall[4];

        // Directed rows. A file always begins with the PNG signature byte.
        stim_table = '{
            '{ROW_PIX, CFG_WIDTH,  14'h00,   1'b1, SIG_FIRST},  // 1x1 after reset
            '{ROW_PIX, CFG_WIDTH,  14'hFF,   1'b0, 8'd0},
            '{ROW_PIX, CFG_WIDTH,  14'hA5,   1'b0, 8'd0},
            '{ROW_CFG, CFG_WIDTH,  14'd0,    1'b0, 8'd0},       // zero means one
            '{ROW_CFG, CFG_HEIGHT, 14'd2,    1'b0, 8'd0},
            '{ROW_PIX, CFG_WIDTH,  14'h5A,   1'b1, SIG_FIRST},
            '{ROW_PIX, CFG_WIDTH,  14'h01,   1'b0, 8'd0},
            '{ROW_PIX, CFG_WIDTH,  14'h80,   1'b0, 8'd0},
            '{ROW_PIX, CFG_WIDTH,  14'h7F,   1'b0, 8'd0},
            '{ROW_PIX, CFG_WIDTH,  14'hFE,   1'b0, 8'd0},
            '{ROW_PIX, CFG_WIDTH,  14'h00,   1'b0, 8'd0},
            '{ROW_CFG, CFG_HEIGHT, 14'd1,    1'b0, 8'd0},
            '{ROW_CFG, CFG_WIDTH,  14'd2,    1'b0, 8'd0},
            '{ROW_PIX, CFG_WIDTH,  14'h11,   1'b1, SIG_FIRST},
            '{ROW_CFG, CFG_WIDTH,  14'h3FFF, 1'b0, 8'd0},       // ignored mid-image
            '{ROW_CFG, CFG_HEIGHT, 14'd0,    1'b0, 8'd0},       // ignored mid-image
            '{ROW_PIX, CFG_WIDTH,  14'h22,   1'b0, 8'd0},
            '{ROW_PIX, CFG_WIDTH,  14'h44,   1'b0, 8'd0},
            '{ROW_PIX, CFG_WIDTH,  14'h88,   1'b0, 8'd0},
            '{ROW_PIX, CFG_WIDTH,  14'hCC,   1'b0, 8'd0},
            '{ROW_PIX, CFG_WIDTH,  14'hEE,   1'b0, 8'd0}
        };
        pct_send  = '{0, 49, 0, 32};
        pct_stall = '{0, 0, 49, 32};

        width_reg = 1;
        height_reg = 1;
        crc_acc = '1;
        adler_lo = 1;
        adler_hi = 0;
        raw_remaining = 0;
        room_left = 0;
        row_pos = 0;
        in_image = 1'b0;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_CFG)
            begin
                write_reg(stim_table[i].index, stim_table[i].value);
            end
            else
            begin
                send_pixel(stim_table[i].value[7:0]);
                if (stim_table[i].known && step_bytes[0].data !== stim_table[i].first_byte)
                begin
                    note_mismatch("file start", stim_table[i].first_byte, step_bytes[0].data);
                end
            end
        end

        // Random small images, one phase per idling mix.
        for (int p = 0; p < 4; p++)
        begin
            drain();
            send_idle_pct = pct_send[p];
            stall_pct = pct_stall[p];
            sent = 0;
            while (sent < 70)
            begin
                run_image(DIM_W'($urandom_range(0, 5)), DIM_W'($urandom_range(0, 4)));
                sent += 3 * clamp_dim(width_reg) * clamp_dim(height_reg);
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        stall_pct = 0;
        while (file_bytes_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (50) @(negedge clk);
        if (file_bytes_due.size() != 0)
        begin
            mismatches++;
        end
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/pngenc_pkg.sv
rtl/core/pngenc_front.sv
rtl/core/pngenc_hdrcalc.sv
rtl/core/pngenc_back.sv
rtl/core/png_rgb_stored_deflate_encoder.sv
verif/tb.sv
